// ===== src/mip_chain_layout_generator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mip chain layout generator
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MIP_CHAIN_LAYOUT_GENERATOR_UNIT_ASSERT_SVH
`define MIP_CHAIN_LAYOUT_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCLG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mclg same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCLG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mclg next-cycle check failed");

`endif

// ===== src/mclg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclg_pkg
// Shared widths, codes, beat layouts and controller types of the mip chain
// layout generator.
// ----------------------------------------------------------------------------
package mclg_pkg;

   localparam int KIND_W          = 2;
   localparam int DIM_W           = 15;
   localparam int LAYER_W         = 12;
   localparam int LEVEL_W         = 4;
   localparam int BLK_W           = 4;
   localparam int BPB_W           = 6;
   localparam int OFF_W           = 48;
   localparam int MAX_LEVELS      = 15;
   localparam int ALIGN_BYTES_DEF = 16;

   // Offset remainder unit: bits of the offset consumed per cycle.
   localparam int REM_DIGITS = 8;
   localparam int REM_STEPS  = OFF_W / REM_DIGITS;

   // Block count divider: dividend is a dimension plus block size minus one.
   localparam int DIV_NUM_W  = DIM_W + 1;
   localparam int DIV_DIGITS = 4;
   localparam int DIV_STEPS  = DIV_NUM_W / DIV_DIGITS;

   localparam int STEP_W = $clog2(REM_STEPS);

   localparam logic [KIND_W-1:0] KIND_1D = 2'd0;
   localparam logic [KIND_W-1:0] KIND_2D = 2'd1;
   localparam logic [KIND_W-1:0] KIND_3D = 2'd2;

   typedef struct packed {
      logic [4:0]         pad;
      logic [BPB_W-1:0]   bytes_per_block;
      logic [BLK_W-1:0]   block_height;
      logic [BLK_W-1:0]   block_width;
      logic [LEVEL_W-1:0] levels_wanted;
      logic [LAYER_W-1:0] layer_count;
      logic [DIM_W-1:0]   base_depth;
      logic [DIM_W-1:0]   base_height;
      logic [DIM_W-1:0]   base_width;
   } req_data_type;

   typedef struct packed {
      logic [2:0]         pad;
      logic [OFF_W-1:0]   total_size;
      logic [DIM_W-1:0]   level_depth;
      logic [DIM_W-1:0]   level_height;
      logic [DIM_W-1:0]   level_width;
      logic [DIM_W-1:0]   padded_column_texels;
      logic [DIM_W-1:0]   padded_row_texels;
      logic [DIM_W-1:0]   blocks_down;
      logic [DIM_W-1:0]   blocks_across;
      logic [OFF_W-1:0]   level_offset;
      logic [LEVEL_W-1:0] level;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ITER,
      ST_MUL1,
      ST_MUL2,
      ST_EMIT
   } mclg_state_type;

   typedef struct packed {
      logic load;
      logic iter_init;
      logic div_step;
      logic rem_step;
      logic mul1;
      logic mul2;
      logic emit;
   } mclg_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } mclg_status_type;

endpackage

// ===== src/mclg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclg_div
// Iterative restoring divider for block counts, several quotient bits a cycle.
// ----------------------------------------------------------------------------
module mclg_div (
   input  logic                            clock,
   input  logic                            start,
   input  logic                            step,
   input  logic [mclg_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [mclg_pkg::BLK_W-1:0]      divisor,
   output logic [mclg_pkg::DIV_NUM_W-1:0]  quotient
);
   import mclg_pkg::*;

   // num_ff shifts the dividend out at the top and the quotient in below.
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [BLK_W-1:0]     rem_ff, rem_in;
   logic [BLK_W-1:0]     den_ff;

   always_comb begin
      logic [BLK_W:0]       trial;
      logic [DIV_NUM_W-1:0] num;
      logic [BLK_W-1:0]     rem;
      num = num_ff;
      rem = rem_ff;
      for (int i = 0; i < DIV_DIGITS; i++) begin
         trial = {rem, num[DIV_NUM_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            trial = trial - {1'b0, den_ff};
            num   = {num[DIV_NUM_W-2:0], 1'b1};
         end else begin
            num   = {num[DIV_NUM_W-2:0], 1'b0};
         end
         rem = trial[BLK_W-1:0];
      end
      num_in = num;
      rem_in = rem;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = num_ff;

endmodule

// ===== src/mclg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclg_dp
// Datapath: descriptor registers, block count dividers, offset alignment,
// level size multipliers and the result register.
// ----------------------------------------------------------------------------
module mclg_dp #(
   parameter int ALIGN_BYTES = mclg_pkg::ALIGN_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mclg_pkg::mclg_cmd_type      cmd,
   output mclg_pkg::mclg_status_type   status,
   input  logic [mclg_pkg::KIND_W-1:0] req_kind,
   input  mclg_pkg::req_data_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mclg_pkg::rsp_data_type      rsp_data,
   output logic                        rsp_last
);
   import mclg_pkg::*;

   localparam int RW     = $clog2(ALIGN_BYTES) + 1;
   localparam int P1_W   = 2 * DIM_W;
   localparam int Q_W    = DIM_W + BPB_W;
   localparam int SIZE_W = P1_W + Q_W;
   localparam int SUM_W  = SIZE_W + 1;
   localparam logic [RW:0] ALIGN_V = (RW + 1)'(ALIGN_BYTES);

   function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] h;
      h = v >> 1;
      return (h == '0) ? DIM_W'(1) : h;
   endfunction

   function automatic logic [LEVEL_W-1:0] bit_length(input logic [DIM_W-1:0] v);
      logic [LEVEL_W-1:0] n;
      n = '0;
      for (int i = 0; i < DIM_W; i++) begin
         if (v[i]) n = LEVEL_W'(i + 1);
      end
      return n;
   endfunction

   // Descriptor and per-level state.
   logic [DIM_W-1:0]   w_ff, h_ff, d_ff;
   logic [LAYER_W-1:0] layers_ff;
   logic               is3d_ff;
   logic [BLK_W-1:0]   bw_ff, bh_ff;
   logic [BPB_W-1:0]   bpb_ff;
   logic [LEVEL_W-1:0] nlev_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [OFF_W-1:0]   off_ff, off_in;

   // Remainder of the running offset modulo the alignment.
   logic [OFF_W-1:0]   offsh_ff;
   logic [RW-1:0]      rem_ff, rem_in;

   // Multiplier stages.
   logic [P1_W-1:0]    p1_ff;
   logic [Q_W-1:0]     q_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [OFF_W-1:0]   offal_ff, offal_in;
   logic [DIM_W-1:0]   padrow_ff, padcol_ff;

   logic [DIV_NUM_W-1:0] quo_x, quo_y;
   logic [DIM_W-1:0]     bx, by;

   // Result register.
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;
   logic               rsp_last_ff;

   // Load-time values after the kind and zero-extent rules.
   logic [DIM_W-1:0]   ld_w, ld_h, ld_d, ld_max;
   logic [LAYER_W-1:0] ld_layers;
   logic [LEVEL_W-1:0] ld_nlev;

   always_comb begin
      ld_w      = (req_data.base_width  == '0) ? DIM_W'(1) : req_data.base_width;
      ld_h      = (req_data.base_height == '0) ? DIM_W'(1) : req_data.base_height;
      ld_d      = (req_data.base_depth  == '0) ? DIM_W'(1) : req_data.base_depth;
      ld_layers = (req_data.layer_count == '0) ? LAYER_W'(1) : req_data.layer_count;
      if (req_kind == KIND_1D) begin
         ld_h = DIM_W'(1);
         ld_d = DIM_W'(1);
      end else if (req_kind == KIND_3D) begin
         ld_layers = LAYER_W'(1);
      end else begin
         ld_d = DIM_W'(1);
      end
      ld_max = ld_w;
      if (ld_h > ld_max) ld_max = ld_h;
      if (ld_d > ld_max) ld_max = ld_d;
      ld_nlev = (req_data.levels_wanted == '0) ? bit_length(ld_max)
                                               : req_data.levels_wanted;
      if (ld_nlev > LEVEL_W'(MAX_LEVELS)) ld_nlev = LEVEL_W'(MAX_LEVELS);
   end

   mclg_div u_div_x (
      .clock    (clock),
      .start    (cmd.iter_init),
      .step     (cmd.div_step),
      .dividend ({1'b0, w_ff} + DIV_NUM_W'(bw_ff) - DIV_NUM_W'(1)),
      .divisor  (bw_ff),
      .quotient (quo_x)
   );

   mclg_div u_div_y (
      .clock    (clock),
      .start    (cmd.iter_init),
      .step     (cmd.div_step),
      .dividend ({1'b0, h_ff} + DIV_NUM_W'(bh_ff) - DIV_NUM_W'(1)),
      .divisor  (bh_ff),
      .quotient (quo_y)
   );

   assign bx = quo_x[DIM_W-1:0];
   assign by = quo_y[DIM_W-1:0];

   // Digit-serial remainder: one offset byte per cycle, most significant first.
   always_comb begin
      logic [RW:0]   trial;
      logic [RW-1:0] rem;
      rem = rem_ff;
      for (int i = 0; i < REM_DIGITS; i++) begin
         trial = {rem, offsh_ff[OFF_W-1-i]};
         if (trial >= ALIGN_V) trial = trial - ALIGN_V;
         rem = trial[RW-1:0];
      end
      rem_in = rem;
   end

   // Round the offset up to the alignment, saturating at the top of the range.
   always_comb begin
      logic [OFF_W:0] up;
      up = {1'b0, off_ff} + (OFF_W + 1)'(ALIGN_V - {1'b0, rem_ff});
      if (rem_ff == '0) begin
         offal_in = off_ff;
      end else if (up[OFF_W]) begin
         offal_in = '1;
      end else begin
         offal_in = up[OFF_W-1:0];
      end
   end

   always_comb begin
      logic [SUM_W-1:0] sum;
      sum = {{(SUM_W - OFF_W){1'b0}}, offal_ff} + {1'b0, size_ff};
      off_in = (sum[SUM_W-1:OFF_W] != '0) ? '1 : sum[OFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff      <= ld_w;
         h_ff      <= ld_h;
         d_ff      <= ld_d;
         layers_ff <= ld_layers;
         is3d_ff   <= (req_kind == KIND_3D);
         bw_ff     <= (req_data.block_width  == '0) ? BLK_W'(1) : req_data.block_width;
         bh_ff     <= (req_data.block_height == '0) ? BLK_W'(1) : req_data.block_height;
         bpb_ff    <= req_data.bytes_per_block;
         nlev_ff   <= ld_nlev;
         level_ff  <= '0;
         off_ff    <= '0;
      end else if (cmd.emit) begin
         w_ff     <= halve(w_ff);
         h_ff     <= halve(h_ff);
         d_ff     <= halve(d_ff);
         level_ff <= level_ff + LEVEL_W'(1);
         off_ff   <= off_in;
      end

      if (cmd.iter_init) begin
         offsh_ff <= off_ff;
         rem_ff   <= '0;
      end else if (cmd.rem_step) begin
         offsh_ff <= offsh_ff << REM_DIGITS;
         rem_ff   <= rem_in;
      end

      if (cmd.mul1) begin
         p1_ff     <= {{DIM_W{1'b0}}, bx} * {{DIM_W{1'b0}}, by};
         // Only one of depth and layers can exceed one for a given kind.
         q_ff      <= {{BPB_W{1'b0}}, (is3d_ff ? d_ff : DIM_W'(layers_ff))}
                      * {{DIM_W{1'b0}}, bpb_ff};
         offal_ff  <= offal_in;
         padrow_ff <= DIM_W'({{BLK_W{1'b0}}, bx} * {{DIM_W{1'b0}}, bw_ff});
         padcol_ff <= DIM_W'({{BLK_W{1'b0}}, by} * {{DIM_W{1'b0}}, bh_ff});
      end

      if (cmd.mul2) begin
         size_ff <= {{Q_W{1'b0}}, p1_ff} * {{P1_W{1'b0}}, q_ff};
      end

      if (cmd.emit) begin
         rsp_data_ff.pad                  <= '0;
         rsp_data_ff.level                <= level_ff;
         rsp_data_ff.level_offset         <= offal_ff;
         rsp_data_ff.blocks_across        <= bx;
         rsp_data_ff.blocks_down          <= by;
         rsp_data_ff.padded_row_texels    <= padrow_ff;
         rsp_data_ff.padded_column_texels <= padcol_ff;
         rsp_data_ff.level_width          <= w_ff;
         rsp_data_ff.level_height         <= h_ff;
         rsp_data_ff.level_depth          <= d_ff;
         rsp_data_ff.total_size           <= off_in;
         rsp_last_ff                      <= status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.last     = ((level_ff + LEVEL_W'(1)) == nlev_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== src/mclg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclg_ctrl
// Controller: sequences each mip level through setup, iteration, two
// multiplier stages and the write into the result register.
// ----------------------------------------------------------------------------
module mclg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mclg_pkg::mclg_status_type status,
   output mclg_pkg::mclg_cmd_type    cmd
);
   import mclg_pkg::*;

   mclg_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (step_ff == STEP_W'(REM_STEPS - 1)) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = status.last ? ST_IDLE : ST_SETUP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      step_in   = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SETUP: begin
            cmd.iter_init = 1'b1;
            step_in       = '0;
         end
         ST_ITER: begin
            cmd.rem_step = 1'b1;
            cmd.div_step = (step_ff < STEP_W'(DIV_STEPS));
            step_in      = step_ff + STEP_W'(1);
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== src/mip_chain_layout_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_chain_layout_generator_unit
// Lays a texture's mip chain out linearly in a buffer, one result beat per
// level, with the aligned start offset, block counts, padded extents and the
// running end offset.
// ----------------------------------------------------------------------------
// Each descriptor beat is taken only while the unit is idle. Every mip level
// then passes through a setup step, an iteration in which the offset
// remainder unit consumes the 48-bit running offset one byte per cycle (the
// two block count dividers finish within it), two multiplier stages for the
// level size, and the write into the result register. A stalled result
// holds the level write until its register frees. Offsets and totals
// saturate at 2^48 - 1.
module mip_chain_layout_generator_unit #(
   parameter int ALIGN_BYTES = mclg_pkg::ALIGN_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // base_width, base_height, base_depth, layer_count, levels_wanted,
   // block_width, block_height, bytes_per_block, zero pad
   input  logic [79:0]  req_tdata,
   // image_kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // level, level_offset, blocks_across, blocks_down, padded_row_texels,
   // padded_column_texels, level_width, level_height, level_depth,
   // total_size, zero pad
   output logic [207:0] rsp_tdata,
   output logic         rsp_tlast
);
   import mclg_pkg::*;
   `include "mip_chain_layout_generator_unit_assert.svh"

   mclg_cmd_type    cmd;
   mclg_status_type status;
   req_data_type    req_data;
   rsp_data_type    rsp_data;

   assign req_data  = req_data_type'(req_tdata);
   assign rsp_tdata = rsp_data;

   mclg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mclg_dp #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_kind  (req_tuser),
      .req_data  (req_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_tlast)
   );

   // A descriptor occupies the unit for at least one full level.
   `MCLG_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // The end offset of a level never lies before its start.
   `MCLG_ASSERT_SAME(a_end_after_start, rsp_tvalid,
                     rsp_data.total_size >= rsp_data.level_offset)
   // The first level always starts at the buffer base.
   `MCLG_ASSERT_SAME(a_level0_at_base, rsp_tvalid && (rsp_data.level == '0),
                     rsp_data.level_offset == '0)

endmodule

// ===== sim/mip_chain_layout_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_chain_layout_generator_unit_tb
// Self-checking bench for the mip chain layout generator. Texture descriptor
// beats are sent with random gaps. A built-in layout predictor works out every
// level beat in advance. The result side stalls at random and twice holds off
// for a long stretch. Each result beat is compared field by field with the
// oldest predicted level.
// ----------------------------------------------------------------------------
module mip_chain_layout_generator_unit_tb;
   import mclg_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 4;
   localparam int RANDOM_ITEMS   = 310;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int TAIL_CYCLES    = 200;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AT_FIRST  = 60;
   localparam int HOLD_AT_SECOND = 220;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam longint unsigned OFFSET_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint unsigned ALIGN = ALIGN_BYTES_DEF;

   typedef struct {
      logic [KIND_W-1:0] kind;
      req_data_type      fields;
      bit                wait_drained;
      int                gap;
   } descriptor_type;

   typedef struct {
      rsp_data_type fields;
      logic         final_level;
   } level_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // base_width, base_height, base_depth, layer_count, levels_wanted,
   // block_width, block_height, bytes_per_block, zero pad
   logic [79:0]  req_tdata;
   // image_kind
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // level, level_offset, blocks_across, blocks_down, padded_row_texels,
   // padded_column_texels, level_width, level_height, level_depth,
   // total_size, zero pad
   logic [207:0] rsp_tdata;
   logic         rsp_tlast;

   descriptor_type   pending_descriptors[$];
   level_result_type expected_levels[$];
   descriptor_type   offered;
   level_result_type want;
   rsp_data_type     got;

   int     gap_left;
   int     accepted = 0;
   int     total_descriptors;
   int     directed_count;
   int     results_checked = 0;
   int     chains_closed = 0;
   int     mismatches = 0;
   int     rsp_stall_left;
   int     hold_left;
   int     holds_started;
   int     stall_draw;
   longint cycle_count = 0;
   logic   hold_active;

   mip_chain_layout_generator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint unsigned at_least_one(input longint unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic longint unsigned halve(input longint unsigned v);
      return ((v >> 1) == 0) ? 1 : (v >> 1);
   endfunction

   // Predicts every level beat of one descriptor and queues them in order.
   function automatic void lay_out_mip_chain(input logic [KIND_W-1:0] kind,
                                             input req_data_type d);
      longint unsigned  w, h, dep, layers, bw, bh, bpb;
      longint unsigned  levels, widest, offset, bytes, bx, by;
      level_result_type r;
      int               i;
      w      = at_least_one(64'(d.base_width));
      h      = at_least_one(64'(d.base_height));
      dep    = at_least_one(64'(d.base_depth));
      layers = at_least_one(64'(d.layer_count));
      bw     = at_least_one(64'(d.block_width));
      bh     = at_least_one(64'(d.block_height));
      bpb    = 64'(d.bytes_per_block);
      levels = 64'(d.levels_wanted);
      offset = 0;
      if (kind == KIND_1D) begin
         h   = 1;
         dep = 1;
      end else if (kind == KIND_3D) begin
         layers = 1;
      end else begin
         dep = 1;
      end
      // A zero level count asks for the whole chain down to one texel.
      if (levels == 0) begin
         widest = w;
         if (h > widest) widest = h;
         if (dep > widest) widest = dep;
         while (widest != 0) begin
            levels++;
            widest >>= 1;
         end
      end
      if (levels > MAX_LEVELS) levels = MAX_LEVELS;
      for (i = 0; i < levels; i++) begin
         bx     = (w + bw - 1) / bw;
         by     = (h + bh - 1) / bh;
         bytes  = bx * by * layers * dep * bpb;
         offset = ((offset + ALIGN - 1) / ALIGN) * ALIGN;
         if (offset > OFFSET_MAX) offset = OFFSET_MAX;
         r.fields                      = '0;
         r.fields.level                = i[LEVEL_W-1:0];
         r.fields.level_offset         = offset[OFF_W-1:0];
         r.fields.blocks_across        = bx[DIM_W-1:0];
         r.fields.blocks_down          = by[DIM_W-1:0];
         r.fields.padded_row_texels    = DIM_W'((bx * bw) & 64'h7FFF);
         r.fields.padded_column_texels = DIM_W'((by * bh) & 64'h7FFF);
         r.fields.level_width          = w[DIM_W-1:0];
         r.fields.level_height         = h[DIM_W-1:0];
         r.fields.level_depth          = dep[DIM_W-1:0];
         offset = offset + bytes;
         if (offset > OFFSET_MAX) offset = OFFSET_MAX;
         r.fields.total_size = offset[OFF_W-1:0];
         r.final_level       = (i + 1 == levels);
         expected_levels.push_back(r);
         w   = halve(w);
         h   = halve(h);
         dep = halve(dep);
      end
   endfunction

   function automatic descriptor_type make_descriptor(input int unsigned kind, w, h, dep,
                                                      layers, levels, bw, bh, bpb);
      descriptor_type item;
      item.kind                   = KIND_W'(kind);
      item.fields                 = '0;
      item.fields.base_width      = DIM_W'(w);
      item.fields.base_height     = DIM_W'(h);
      item.fields.base_depth      = DIM_W'(dep);
      item.fields.layer_count     = LAYER_W'(layers);
      item.fields.levels_wanted   = LEVEL_W'(levels);
      item.fields.block_width     = BLK_W'(bw);
      item.fields.block_height    = BLK_W'(bh);
      item.fields.bytes_per_block = BPB_W'(bpb);
      item.wait_drained           = 1'b0;
      item.gap                    = idle_cycles();
      return item;
   endfunction

   // Extents drawn up to a random power of two, at most 16384.
   function automatic int unsigned random_extent();
      return $urandom_range(1, 1 << $urandom_range(0, 14));
   endfunction

   function automatic descriptor_type random_descriptor();
      int          pick;
      int unsigned kind, levels, bw, bh, bpb;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // Raw bit patterns reach the values outside the usual ranges.
         return make_descriptor($urandom_range(0, 3), $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      kind   = (pick < 16) ? KIND_UNUSED : $urandom_range(0, 2);
      levels = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15);
      if ($urandom_range(0, 9) < 6) begin
         bw = 1;
         bh = 1;
      end else begin
         bw = $urandom_range(1, 12);
         bh = $urandom_range(0, 1) ? bw : $urandom_range(1, 12);
      end
      bpb = $urandom_range(0, 1) ? (1 << $urandom_range(0, 5)) : $urandom_range(0, 32);
      return make_descriptor(kind, random_extent(), random_extent(), random_extent(),
                             $urandom_range(1, 1 << $urandom_range(0, 11)),
                             levels, bw, bh, bpb);
   endfunction

   task automatic check_field(input string name, input logic [63:0] expected_value,
                              input logic [63:0] actual_value);
      if (expected_value !== actual_value) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch in %s of result %0d: expected %0h, got %0h",
                     name, results_checked, expected_value, actual_value);
         end
      end
   endtask

   // Descriptor driver: offers the next pending beat once the previous one
   // is taken and its gap has passed.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            lay_out_mip_chain(offered.kind, offered.fields);
            accepted <= accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_descriptors.size() != 0 &&
                         !(pending_descriptors[0].wait_drained &&
                           expected_levels.size() != 0)) begin
               offered = pending_descriptors.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered.fields;
               req_tuser  <= offered.kind;
               gap_left   <= offered.gap;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long hold-offs of the result side, started twice by the number of
   // accepted descriptors so that the unit backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left     <= 0;
         holds_started <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_started == 0 && accepted >= HOLD_AT_FIRST) ||
                   (holds_started == 1 && accepted >= HOLD_AT_SECOND)) begin
         hold_left     <= HOLD_CYCLES;
         holds_started <= holds_started + 1;
      end
   end

   assign hold_active = (hold_left != 0);

   // Result monitor and ready generation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected result beat: %0h", rsp_tdata);
               end
            end else begin
               want = expected_levels.pop_front();
               got  = rsp_tdata;
               check_field("level", 64'(want.fields.level), 64'(got.level));
               check_field("level_offset", 64'(want.fields.level_offset),
                           64'(got.level_offset));
               check_field("blocks_across", 64'(want.fields.blocks_across),
                           64'(got.blocks_across));
               check_field("blocks_down", 64'(want.fields.blocks_down),
                           64'(got.blocks_down));
               check_field("padded_row_texels", 64'(want.fields.padded_row_texels),
                           64'(got.padded_row_texels));
               check_field("padded_column_texels", 64'(want.fields.padded_column_texels),
                           64'(got.padded_column_texels));
               check_field("level_width", 64'(want.fields.level_width),
                           64'(got.level_width));
               check_field("level_height", 64'(want.fields.level_height),
                           64'(got.level_height));
               check_field("level_depth", 64'(want.fields.level_depth),
                           64'(got.level_depth));
               check_field("total_size", 64'(want.fields.total_size),
                           64'(got.total_size));
               check_field("last_level", 64'(want.final_level), 64'(rsp_tlast));
               if (want.final_level) chains_closed++;
            end
            results_checked++;
         end
         if (hold_active) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_tready     <= 1'b0;
         end else if ((results_checked / 150) % 3 == 1) begin
            // A stretch with the receiver always ready.
            rsp_tready <= 1'b1;
         end else begin
            stall_draw = idle_cycles();
            rsp_stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
            rsp_tready     <= (stall_draw == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycle_count, expected_levels.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      descriptor_type item;
      int             i;
      reset = 1'b1;

      // Directed descriptors: extremes, every kind and the corner cases.
      // 1D ignores height and depth; the full chain runs to one texel.
      pending_descriptors.push_back(make_descriptor(KIND_1D, 16384, 5, 9, 3, 0, 1, 1, 4));
      pending_descriptors.push_back(make_descriptor(KIND_1D, 1, 0, 0, 1, 0, 1, 1, 1));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 16384, 16384, 1, 2048, 0,
                                                    1, 1, 32));
      pending_descriptors.push_back(make_descriptor(KIND_3D, 16384, 16384, 16384, 2048, 0,
                                                    1, 1, 32));
      // Large enough that offsets and totals saturate.
      pending_descriptors.push_back(make_descriptor(KIND_3D, 32767, 32767, 32767, 4095, 0,
                                                    1, 1, 63));
      // The unused kind behaves as 2D.
      pending_descriptors.push_back(make_descriptor(KIND_UNUSED, 640, 480, 7, 6, 0,
                                                    4, 4, 16));
      // Zero extents, layer count and block sizes all read as one.
      pending_descriptors.push_back(make_descriptor(KIND_3D, 0, 0, 0, 0, 3, 1, 1, 8));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 0, 37, 1, 0, 0, 0, 0, 4));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 1000, 600, 1, 1, 0, 4, 4, 16));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 13, 25, 1, 3, 0, 12, 12, 16));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 100, 100, 1, 1, 0, 15, 13, 16));
      // Asking for more levels than the chain has keeps emitting 1x1x1.
      pending_descriptors.push_back(make_descriptor(KIND_2D, 4, 4, 1, 1, 15, 1, 1, 4));
      pending_descriptors.push_back(make_descriptor(KIND_3D, 8, 2, 32, 5, 15, 1, 1, 2));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 256, 256, 1, 1, 1, 1, 1, 4));
      // Unknown format: every level is empty.
      pending_descriptors.push_back(make_descriptor(KIND_2D, 300, 200, 1, 4, 0, 8, 8, 0));
      // Padded row length wraps past 15 bits.
      pending_descriptors.push_back(make_descriptor(KIND_1D, 32767, 0, 0, 4095, 0,
                                                    15, 1, 63));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 32767, 32767, 32767, 4095, 15,
                                                    15, 15, 63));
      pending_descriptors.push_back(make_descriptor(KIND_3D, 7, 5, 3, 9, 0, 5, 4, 12));
      pending_descriptors.push_back(make_descriptor(KIND_2D, 1, 16384, 1, 1, 0, 1, 12, 8));
      pending_descriptors.push_back(make_descriptor(KIND_1D, 2048, 1, 1, 2048, 6, 4, 1, 8));
      pending_descriptors.push_back(make_descriptor(KIND_3D, 1, 1, 16384, 1, 0, 1, 1, 1));
      directed_count = pending_descriptors.size();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         item = random_descriptor();
         // Now and then the sender waits for the unit to drain completely.
         if (i % 100 == 40) item.wait_drained = 1'b1;
         if (i >= 120 && i < 160) item.gap = 0;
         pending_descriptors.push_back(item);
      end
      total_descriptors = pending_descriptors.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted != total_descriptors) @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d descriptors (%0d directed) across all image kinds,",
               total_descriptors, directed_count);
      $display("checked %0d level beats closing %0d chains, %0d mismatches",
               results_checked, chains_closed, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/mclg_pkg.sv
src/mclg_div.sv
src/mclg_dp.sv
src/mclg_ctrl.sv
src/mip_chain_layout_generator_unit.sv
sim/mip_chain_layout_generator_unit_tb.sv
